// ===== hdl/vpci_pkg.sv =====
// Shared types, codes and saturating arithmetic for the vector path command interpreter.
package vpci_pkg;

  localparam int COORD_BITS = 32;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS+1:0] wide_t;

  localparam wide_t WIDE_MAX = wide_t'({1'b0, {(COORD_BITS-1){1'b1}}});
  localparam wide_t WIDE_MIN = -WIDE_MAX - wide_t'(1);

  localparam logic [3:0] CMD_MOVE         = 4'd0;
  localparam logic [3:0] CMD_CLOSE        = 4'd1;
  localparam logic [3:0] CMD_LINE         = 4'd2;
  localparam logic [3:0] CMD_HORIZ        = 4'd3;
  localparam logic [3:0] CMD_VERT         = 4'd4;
  localparam logic [3:0] CMD_CUBIC        = 4'd5;
  localparam logic [3:0] CMD_SMOOTH_CUBIC = 4'd6;
  localparam logic [3:0] CMD_QUAD         = 4'd7;
  localparam logic [3:0] CMD_SMOOTH_QUAD  = 4'd8;
  localparam logic [3:0] CMD_ARC          = 4'd9;
  localparam logic [3:0] CMD_END          = 4'd10;

  typedef enum logic [2:0] {
    KIND_BEGIN      = 3'd0,
    KIND_LINE       = 3'd1,
    KIND_CUBIC      = 3'd2,
    KIND_QUAD       = 3'd3,
    KIND_ARC        = 3'd4,
    KIND_END_OPEN   = 3'd5,
    KIND_END_CLOSED = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic       last;
    coord_t     first_x;
    coord_t     first_y;
    coord_t     second_x;
    coord_t     second_y;
    coord_t     point_x;
    coord_t     point_y;
    logic [1:0] arc_bits;
    logic       path_rule;
  } result_t;

  function automatic coord_t clamp_wide(input wide_t v);
    coord_t r;
    if (v > WIDE_MAX) r = WIDE_MAX[COORD_BITS-1:0];
    else if (v < WIDE_MIN) r = WIDE_MIN[COORD_BITS-1:0];
    else r = v[COORD_BITS-1:0];
    return r;
  endfunction

  function automatic coord_t sat_add(input coord_t a, input coord_t b);
    wide_t s;
    s = wide_t'(a) + wide_t'(b);
    return clamp_wide(s);
  endfunction

  // 2 * cur - ctl, exact, then saturated
  function automatic coord_t reflect(input coord_t cur, input coord_t ctl);
    wide_t t;
    t = (wide_t'(cur) <<< 1) - wide_t'(ctl);
    return clamp_wide(t);
  endfunction

  function automatic coord_t place(input logic rel, input coord_t base, input coord_t raw);
    coord_t r;
    r = rel ? sat_add(base, raw) : raw;
    return r;
  endfunction

  function automatic result_t blank(input kind_t k, input logic rule);
    result_t r;
    r = '0;
    r.kind = k;
    r.path_rule = rule;
    return r;
  endfunction

endpackage

// ===== hdl/vector_path_command_interpreter_top.sv =====
// Top level of the vector path command interpreter.
//
// Input channel (in_*): one tokenized path command per word, accepted when
// in_valid is high and in_stall is low. Output channel (out_*): absolute path
// elements, one per word, taken when out_valid is high and out_stall is low.
// Each command yields zero, one or two output words; out_last marks the final
// word of a command. cfg_wr_en/cfg_wr_data set the fill rule tagged on words.
// All work is done in the accept cycle: the words are registered in a
// two-entry result queue and appear in the cycle after the command is taken.
// Throughput: one command per cycle for commands with at most one word, while
// out_stall is low; a segment that opens a subpath emits a begin word first, and
// the next command waits while the single output port drains the queue one word a cycle.
// in_stall rises whenever the queue cannot be emptied in the current cycle,
// so a stalled receiver holds the queue head and backs up the input.
// Reset clears the current point, subpath start, control point, flags, the
// fill rule and the queue.
module vector_path_command_interpreter_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [3:0]                  in_command,
  input  logic                        in_relative,
  input  logic signed [31:0]          in_a_x,
  input  logic signed [31:0]          in_a_y,
  input  logic signed [31:0]          in_b_x,
  input  logic signed [31:0]          in_b_y,
  input  logic signed [31:0]          in_end_x,
  input  logic signed [31:0]          in_end_y,
  input  logic [1:0]                  in_arc_flags,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_kind,
  output logic                        out_last,
  output logic signed [31:0]          out_first_x,
  output logic signed [31:0]          out_first_y,
  output logic signed [31:0]          out_second_x,
  output logic signed [31:0]          out_second_y,
  output logic signed [31:0]          out_point_x,
  output logic signed [31:0]          out_point_y,
  output logic [1:0]                  out_arc_bits,
  output logic                        out_path_rule
);

  logic fill_rule_r;

  vpci_pkg::coord_t cur_x_r, cur_y_r, start_x_r, start_y_r, ctl_x_r, ctl_y_r;
  vpci_pkg::coord_t cur_x_nxt, cur_y_nxt, start_x_nxt, start_y_nxt, ctl_x_nxt, ctl_y_nxt;
  logic cubic_before_r, quad_before_r, open_r, seen_r;
  logic cubic_before_nxt, quad_before_nxt, open_nxt, seen_nxt;

  vpci_pkg::result_t q0_r, q1_r;
  logic [1:0]        occ_r;

  vpci_pkg::result_t res0, res1, seg;
  logic [1:0]        n_res;
  logic              accept, pop, do_seal;
  vpci_pkg::coord_t  px, py, org_x, org_y;

  assign pop      = (occ_r != 2'd0) && !out_stall;
  assign in_stall = !((occ_r == 2'd0) || ((occ_r == 2'd1) && !out_stall));
  assign accept   = in_valid && !in_stall;
  assign do_seal  = open_r && seen_r;
  assign org_x    = open_r ? start_x_r : cur_x_r;
  assign org_y    = open_r ? start_y_r : cur_y_r;

  always_comb begin
    cur_x_nxt        = cur_x_r;
    cur_y_nxt        = cur_y_r;
    start_x_nxt      = start_x_r;
    start_y_nxt      = start_y_r;
    ctl_x_nxt        = ctl_x_r;
    ctl_y_nxt        = ctl_y_r;
    cubic_before_nxt = cubic_before_r;
    quad_before_nxt  = quad_before_r;
    open_nxt         = open_r;
    seen_nxt         = seen_r;
    res0             = vpci_pkg::blank(vpci_pkg::KIND_END_OPEN, fill_rule_r);
    res1             = '0;
    seg              = vpci_pkg::blank(vpci_pkg::KIND_LINE, fill_rule_r);
    n_res            = 2'd0;

    px = vpci_pkg::place(in_relative, cur_x_r, in_end_x);
    py = vpci_pkg::place(in_relative, cur_y_r, in_end_y);

    case (in_command)
      vpci_pkg::CMD_MOVE: begin
        n_res            = do_seal ? 2'd1 : 2'd0;
        cur_x_nxt        = px;
        cur_y_nxt        = py;
        start_x_nxt      = px;
        start_y_nxt      = py;
        open_nxt         = 1'b1;
        seen_nxt         = 1'b0;
        cubic_before_nxt = 1'b0;
        quad_before_nxt  = 1'b0;
      end
      vpci_pkg::CMD_CLOSE: begin
        res0.kind        = vpci_pkg::KIND_END_CLOSED;
        n_res            = do_seal ? 2'd1 : 2'd0;
        cur_x_nxt        = start_x_r;
        cur_y_nxt        = start_y_r;
        open_nxt         = 1'b0;
        seen_nxt         = 1'b0;
        cubic_before_nxt = 1'b0;
        quad_before_nxt  = 1'b0;
      end
      vpci_pkg::CMD_END: begin
        n_res            = do_seal ? 2'd1 : 2'd0;
        cur_x_nxt        = '0;
        cur_y_nxt        = '0;
        start_x_nxt      = '0;
        start_y_nxt      = '0;
        ctl_x_nxt        = '0;
        ctl_y_nxt        = '0;
        open_nxt         = 1'b0;
        seen_nxt         = 1'b0;
        cubic_before_nxt = 1'b0;
        quad_before_nxt  = 1'b0;
      end
      vpci_pkg::CMD_LINE, vpci_pkg::CMD_HORIZ, vpci_pkg::CMD_VERT,
      vpci_pkg::CMD_CUBIC, vpci_pkg::CMD_SMOOTH_CUBIC, vpci_pkg::CMD_QUAD,
      vpci_pkg::CMD_SMOOTH_QUAD, vpci_pkg::CMD_ARC: begin
        if (in_command == vpci_pkg::CMD_HORIZ) py = cur_y_r;
        if (in_command == vpci_pkg::CMD_VERT)  px = cur_x_r;
        seg.point_x = px;
        seg.point_y = py;
        case (in_command)
          vpci_pkg::CMD_CUBIC, vpci_pkg::CMD_SMOOTH_CUBIC: begin
            seg.kind = vpci_pkg::KIND_CUBIC;
            if (in_command == vpci_pkg::CMD_CUBIC) begin
              seg.first_x = vpci_pkg::place(in_relative, cur_x_r, in_a_x);
              seg.first_y = vpci_pkg::place(in_relative, cur_y_r, in_a_y);
            end else if (cubic_before_r) begin
              seg.first_x = vpci_pkg::reflect(cur_x_r, ctl_x_r);
              seg.first_y = vpci_pkg::reflect(cur_y_r, ctl_y_r);
            end else begin
              seg.first_x = cur_x_r;
              seg.first_y = cur_y_r;
            end
            seg.second_x = vpci_pkg::place(in_relative, cur_x_r, in_b_x);
            seg.second_y = vpci_pkg::place(in_relative, cur_y_r, in_b_y);
            ctl_x_nxt    = seg.second_x;
            ctl_y_nxt    = seg.second_y;
          end
          vpci_pkg::CMD_QUAD, vpci_pkg::CMD_SMOOTH_QUAD: begin
            seg.kind = vpci_pkg::KIND_QUAD;
            if (in_command == vpci_pkg::CMD_QUAD) begin
              seg.first_x = vpci_pkg::place(in_relative, cur_x_r, in_a_x);
              seg.first_y = vpci_pkg::place(in_relative, cur_y_r, in_a_y);
            end else if (quad_before_r) begin
              seg.first_x = vpci_pkg::reflect(cur_x_r, ctl_x_r);
              seg.first_y = vpci_pkg::reflect(cur_y_r, ctl_y_r);
            end else begin
              seg.first_x = cur_x_r;
              seg.first_y = cur_y_r;
            end
            ctl_x_nxt = seg.first_x;
            ctl_y_nxt = seg.first_y;
          end
          vpci_pkg::CMD_ARC: begin
            // radii and rotation are never offset
            seg.kind     = vpci_pkg::KIND_ARC;
            seg.first_x  = in_a_x;
            seg.first_y  = in_a_y;
            seg.second_x = in_b_x;
            seg.arc_bits = in_arc_flags;
          end
          default: begin
            seg.kind = vpci_pkg::KIND_LINE;
          end
        endcase
        cubic_before_nxt = (seg.kind == vpci_pkg::KIND_CUBIC);
        quad_before_nxt  = (seg.kind == vpci_pkg::KIND_QUAD);
        if (!open_r) begin
          start_x_nxt = cur_x_r;
          start_y_nxt = cur_y_r;
        end
        open_nxt  = 1'b1;
        seen_nxt  = 1'b1;
        cur_x_nxt = px;
        cur_y_nxt = py;
        // lead with a begin word when the subpath has no segment yet
        if (!(open_r && seen_r)) begin
          res0         = vpci_pkg::blank(vpci_pkg::KIND_BEGIN, fill_rule_r);
          res0.point_x = org_x;
          res0.point_y = org_y;
          res1         = seg;
          n_res        = 2'd2;
        end else begin
          res0  = seg;
          n_res = 2'd1;
        end
      end
      default: begin
        // unknown code: drop it, no words, no state change
        n_res = 2'd0;
      end
    endcase

    res0.last = (n_res == 2'd1);
    res1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_rule_r    <= 1'b0;
      cur_x_r        <= '0;
      cur_y_r        <= '0;
      start_x_r      <= '0;
      start_y_r      <= '0;
      ctl_x_r        <= '0;
      ctl_y_r        <= '0;
      cubic_before_r <= 1'b0;
      quad_before_r  <= 1'b0;
      open_r         <= 1'b0;
      seen_r         <= 1'b0;
      occ_r          <= 2'd0;
    end else begin
      if (cfg_wr_en) fill_rule_r <= cfg_wr_data;
      if (accept) begin
        cur_x_r        <= cur_x_nxt;
        cur_y_r        <= cur_y_nxt;
        start_x_r      <= start_x_nxt;
        start_y_r      <= start_y_nxt;
        ctl_x_r        <= ctl_x_nxt;
        ctl_y_r        <= ctl_y_nxt;
        cubic_before_r <= cubic_before_nxt;
        quad_before_r  <= quad_before_nxt;
        open_r         <= open_nxt;
        seen_r         <= seen_nxt;
        // queue is empty after this cycle's pop, so refill from the front
        occ_r          <= n_res;
      end else if (pop) begin
        occ_r <= occ_r - 2'd1;
      end
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      q0_r <= res0;
      q1_r <= res1;
    end else if (pop) begin
      q0_r <= q1_r;
    end
  end

  assign out_valid     = (occ_r != 2'd0);
  assign out_kind      = q0_r.kind;
  assign out_last      = q0_r.last;
  assign out_first_x   = q0_r.first_x;
  assign out_first_y   = q0_r.first_y;
  assign out_second_x  = q0_r.second_x;
  assign out_second_y  = q0_r.second_y;
  assign out_point_x   = q0_r.point_x;
  assign out_point_y   = q0_r.point_y;
  assign out_arc_bits  = q0_r.arc_bits;
  assign out_path_rule = q0_r.path_rule;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the vector path command interpreter.
`timescale 1ns / 1ps

module testbench;

  localparam vpci_pkg::coord_t COORD_TOP    = 32'sh7fff_ffff;
  localparam vpci_pkg::coord_t COORD_BOTTOM = 32'sh8000_0000;
  localparam logic signed [33:0] WIDE_TOP    = (34'sd1 <<< 31) - 34'sd1;
  localparam logic signed [33:0] WIDE_BOTTOM = -(34'sd1 <<< 31);
  localparam int IDLE_LIMIT = 1000;

  typedef struct {
    logic [3:0]       cmd;
    logic             rel;
    vpci_pkg::coord_t ax;
    vpci_pkg::coord_t ay;
    vpci_pkg::coord_t bx;
    vpci_pkg::coord_t by;
    vpci_pkg::coord_t ex;
    vpci_pkg::coord_t ey;
    logic [1:0]       flags;
  } path_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] in_command = '0;
  logic in_relative = 1'b0;
  vpci_pkg::coord_t in_a_x = '0;
  vpci_pkg::coord_t in_a_y = '0;
  vpci_pkg::coord_t in_b_x = '0;
  vpci_pkg::coord_t in_b_y = '0;
  vpci_pkg::coord_t in_end_x = '0;
  vpci_pkg::coord_t in_end_y = '0;
  logic [1:0] in_arc_flags = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_kind;
  logic out_last;
  vpci_pkg::coord_t out_first_x, out_first_y, out_second_x, out_second_y;
  vpci_pkg::coord_t out_point_x, out_point_y;
  logic [1:0] out_arc_bits;
  logic out_path_rule;

  vector_path_command_interpreter_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_relative  (in_relative),
    .in_a_x       (in_a_x),
    .in_a_y       (in_a_y),
    .in_b_x       (in_b_x),
    .in_b_y       (in_b_y),
    .in_end_x     (in_end_x),
    .in_end_y     (in_end_y),
    .in_arc_flags (in_arc_flags),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_last     (out_last),
    .out_first_x  (out_first_x),
    .out_first_y  (out_first_y),
    .out_second_x (out_second_x),
    .out_second_y (out_second_y),
    .out_point_x  (out_point_x),
    .out_point_y  (out_point_y),
    .out_arc_bits (out_arc_bits),
    .out_path_rule(out_path_rule)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  path_cmd_t         pending_cmds[$];
  vpci_pkg::result_t expected_words[$];
  int                mismatch_count = 0;

  // Path tracker state, mirrored from the block's behavior
  logic             rule_copy = 1'b0;
  vpci_pkg::coord_t pen_x = '0, pen_y = '0, origin_x = '0, origin_y = '0;
  vpci_pkg::coord_t ctl_x = '0, ctl_y = '0;
  logic   after_cubic = 1'b0, after_quad = 1'b0, sub_open = 1'b0, has_segments = 1'b0;

  task automatic expect_word(input vpci_pkg::result_t w);
    expected_words.insert(expected_words.size(), w);
  endtask

  task automatic queue_cmd(input path_cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  function automatic vpci_pkg::coord_t clip(input logic signed [33:0] v);
    if (v > WIDE_TOP) return COORD_TOP;
    if (v < WIDE_BOTTOM) return COORD_BOTTOM;
    return v[31:0];
  endfunction

  function automatic vpci_pkg::coord_t offset_add(input vpci_pkg::coord_t a,
                                                  input vpci_pkg::coord_t b);
    return clip(34'(a) + 34'(b));
  endfunction

  function automatic vpci_pkg::coord_t mirror(input vpci_pkg::coord_t cur,
                                              input vpci_pkg::coord_t ctl);
    return clip((34'(cur) <<< 1) - 34'(ctl));
  endfunction

  function automatic vpci_pkg::coord_t locate(input logic rel, input vpci_pkg::coord_t base,
                                              input vpci_pkg::coord_t raw);
    return rel ? offset_add(base, raw) : raw;
  endfunction

  function automatic vpci_pkg::result_t make_word(input vpci_pkg::kind_t k,
                                                  input vpci_pkg::coord_t fx,
                                                  input vpci_pkg::coord_t fy,
                                                  input vpci_pkg::coord_t sx,
                                                  input vpci_pkg::coord_t sy,
                                                  input vpci_pkg::coord_t px,
                                                  input vpci_pkg::coord_t py,
                                                  input logic [1:0] bits);
    vpci_pkg::result_t w;
    w.kind = k;
    w.last = 1'b0;
    w.first_x = fx;
    w.first_y = fy;
    w.second_x = sx;
    w.second_y = sy;
    w.point_x = px;
    w.point_y = py;
    w.arc_bits = bits;
    w.path_rule = rule_copy;
    return w;
  endfunction

  task automatic end_subpath(input vpci_pkg::kind_t k);
    if (sub_open && has_segments) expect_word(make_word(k, 0, 0, 0, 0, 0, 0, 0));
    sub_open = 1'b0;
    has_segments = 1'b0;
  endtask

  task automatic predict_command(input path_cmd_t c);
    int               n_before;
    vpci_pkg::kind_t  k;
    vpci_pkg::coord_t fx, fy, sx, sy, px, py;
    logic [1:0] bits;
    n_before = expected_words.size();
    k = vpci_pkg::KIND_LINE;
    fx = '0; fy = '0; sx = '0; sy = '0;
    bits = '0;
    if (c.cmd > vpci_pkg::CMD_END) return;
    case (c.cmd)
      vpci_pkg::CMD_MOVE: begin
        end_subpath(vpci_pkg::KIND_END_OPEN);
        pen_x = locate(c.rel, pen_x, c.ex);
        pen_y = locate(c.rel, pen_y, c.ey);
        origin_x = pen_x;
        origin_y = pen_y;
        sub_open = 1'b1;
        after_cubic = 1'b0;
        after_quad = 1'b0;
      end
      vpci_pkg::CMD_CLOSE: begin
        end_subpath(vpci_pkg::KIND_END_CLOSED);
        pen_x = origin_x;
        pen_y = origin_y;
        after_cubic = 1'b0;
        after_quad = 1'b0;
      end
      vpci_pkg::CMD_END: begin
        end_subpath(vpci_pkg::KIND_END_OPEN);
        pen_x = '0; pen_y = '0; origin_x = '0; origin_y = '0; ctl_x = '0; ctl_y = '0;
        after_cubic = 1'b0;
        after_quad = 1'b0;
      end
      default: begin
        // open a subpath implicitly at the pen position
        if (!sub_open) begin
          origin_x = pen_x;
          origin_y = pen_y;
          sub_open = 1'b1;
          has_segments = 1'b0;
        end
        if (!has_segments)
          expect_word(make_word(vpci_pkg::KIND_BEGIN, 0, 0, 0, 0, origin_x, origin_y, 0));
        px = locate(c.rel, pen_x, c.ex);
        py = locate(c.rel, pen_y, c.ey);
        case (c.cmd)
          vpci_pkg::CMD_HORIZ: py = pen_y;
          vpci_pkg::CMD_VERT:  px = pen_x;
          vpci_pkg::CMD_CUBIC, vpci_pkg::CMD_SMOOTH_CUBIC: begin
            k = vpci_pkg::KIND_CUBIC;
            if (c.cmd == vpci_pkg::CMD_CUBIC) begin
              fx = locate(c.rel, pen_x, c.ax);
              fy = locate(c.rel, pen_y, c.ay);
            end else if (after_cubic) begin
              fx = mirror(pen_x, ctl_x);
              fy = mirror(pen_y, ctl_y);
            end else begin
              fx = pen_x;
              fy = pen_y;
            end
            sx = locate(c.rel, pen_x, c.bx);
            sy = locate(c.rel, pen_y, c.by);
            ctl_x = sx;
            ctl_y = sy;
          end
          vpci_pkg::CMD_QUAD, vpci_pkg::CMD_SMOOTH_QUAD: begin
            k = vpci_pkg::KIND_QUAD;
            if (c.cmd == vpci_pkg::CMD_QUAD) begin
              fx = locate(c.rel, pen_x, c.ax);
              fy = locate(c.rel, pen_y, c.ay);
            end else if (after_quad) begin
              fx = mirror(pen_x, ctl_x);
              fy = mirror(pen_y, ctl_y);
            end else begin
              fx = pen_x;
              fy = pen_y;
            end
            ctl_x = fx;
            ctl_y = fy;
          end
          vpci_pkg::CMD_ARC: begin
            // radii and rotation are never offset
            k = vpci_pkg::KIND_ARC;
            fx = c.ax;
            fy = c.ay;
            sx = c.bx;
            bits = c.flags;
          end
          default: ;
        endcase
        after_cubic = (k == vpci_pkg::KIND_CUBIC);
        after_quad = (k == vpci_pkg::KIND_QUAD);
        expect_word(make_word(k, fx, fy, sx, sy, px, py, bits));
        has_segments = 1'b1;
        pen_x = px;
        pen_y = py;
      end
    endcase
    if (expected_words.size() > n_before) expected_words[$].last = 1'b1;
  endtask

  // Driver: bursts of words with random gaps
  path_cmd_t cur_cmd;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_command(cur_cmd);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          in_command <= cur_cmd.cmd;
          in_relative <= cur_cmd.rel;
          in_a_x <= cur_cmd.ax;
          in_a_y <= cur_cmd.ay;
          in_b_x <= cur_cmd.bx;
          in_b_y <= cur_cmd.by;
          in_end_x <= cur_cmd.ex;
          in_end_y <= cur_cmd.ey;
          in_arc_flags <= cur_cmd.flags;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: free, coin flip, one in three, or held solid
  int stall_mode = 0;
  int mode_left = 0;
  int stall_tick = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = (stall_mode == 3) ? $urandom_range(1, 40) : $urandom_range(10, 80);
      end
      mode_left--;
      stall_tick++;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= 1'($urandom_range(0, 1));
        2: out_stall <= (stall_tick % 3 == 0);
        default: out_stall <= 1'b1;
      endcase
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Monitor: compare each taken word with the oldest prediction
  always @(posedge clk) begin
    vpci_pkg::result_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected output word, kind %0d", out_kind);
        mismatch_count++;
      end else begin
        w = expected_words.pop_front();
        check_field("kind", 32'(w.kind), 32'(out_kind));
        check_field("last", 32'(w.last), 32'(out_last));
        check_field("first_x", w.first_x, out_first_x);
        check_field("first_y", w.first_y, out_first_y);
        check_field("second_x", w.second_x, out_second_x);
        check_field("second_y", w.second_y, out_second_y);
        check_field("point_x", w.point_x, out_point_x);
        check_field("point_y", w.point_y, out_point_y);
        check_field("arc_bits", 32'(w.arc_bits), 32'(out_arc_bits));
        check_field("path_rule", 32'(w.path_rule), 32'(out_path_rule));
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic vpci_pkg::coord_t rand_coord();
    int unsigned spread;
    spread = $urandom_range(0, 32'h0004_0000);
    case ($urandom_range(0, 9))
      0: return COORD_TOP;
      1: return COORD_BOTTOM;
      2: return '0;
      3, 4, 5: return vpci_pkg::coord_t'(spread) - vpci_pkg::coord_t'(32'h0002_0000);
      default: return vpci_pkg::coord_t'($urandom);
    endcase
  endfunction

  function automatic path_cmd_t rand_cmd(input logic [3:0] cmd);
    path_cmd_t c;
    c.cmd = cmd;
    c.rel = 1'($urandom_range(0, 1));
    c.ax = rand_coord();
    c.ay = rand_coord();
    c.bx = rand_coord();
    c.by = rand_coord();
    c.ex = rand_coord();
    c.ey = rand_coord();
    c.flags = 2'($urandom_range(0, 3));
    return c;
  endfunction

  task automatic add_cmd(input logic [3:0] cmd, input logic rel, input vpci_pkg::coord_t ax,
                         input vpci_pkg::coord_t ay, input vpci_pkg::coord_t bx,
                         input vpci_pkg::coord_t by, input vpci_pkg::coord_t ex,
                         input vpci_pkg::coord_t ey, input logic [1:0] flags);
    path_cmd_t c;
    c.cmd = cmd;
    c.rel = rel;
    c.ax = ax;
    c.ay = ay;
    c.bx = bx;
    c.by = by;
    c.ex = ex;
    c.ey = ey;
    c.flags = flags;
    queue_cmd(c);
  endtask

  // Mostly well-formed subpaths with random content, plus noise and broken sequences
  task automatic queue_random_paths(input int target);
    int n;
    int segs;
    logic [3:0] seg;
    logic [3:0] prev;
    path_cmd_t c;
    n = 0;
    while (n < target) begin
      case ($urandom_range(0, 19))
        0: begin
          c = rand_cmd(4'($urandom));
          queue_cmd(c);
          if (c.cmd <= vpci_pkg::CMD_END) n++;
        end
        1: begin
          // stray close, end or segment outside any move
          case ($urandom_range(0, 2))
            0: c = rand_cmd(vpci_pkg::CMD_CLOSE);
            1: c = rand_cmd(vpci_pkg::CMD_END);
            default: c = rand_cmd(4'($urandom_range(vpci_pkg::CMD_LINE, vpci_pkg::CMD_ARC)));
          endcase
          queue_cmd(c);
          n++;
        end
        default: begin
          if ($urandom_range(0, 7) != 0) begin
            queue_cmd(rand_cmd(vpci_pkg::CMD_MOVE));
            n++;
          end
          segs = $urandom_range(1, 8);
          prev = vpci_pkg::CMD_MOVE;
          repeat (segs) begin
            seg = 4'($urandom_range(vpci_pkg::CMD_LINE, vpci_pkg::CMD_ARC));
            if ((prev == vpci_pkg::CMD_CUBIC || prev == vpci_pkg::CMD_SMOOTH_CUBIC) &&
                $urandom_range(0, 1))
              seg = vpci_pkg::CMD_SMOOTH_CUBIC;
            if ((prev == vpci_pkg::CMD_QUAD || prev == vpci_pkg::CMD_SMOOTH_QUAD) &&
                $urandom_range(0, 1))
              seg = vpci_pkg::CMD_SMOOTH_QUAD;
            queue_cmd(rand_cmd(seg));
            prev = seg;
            n++;
          end
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
              queue_cmd(rand_cmd(vpci_pkg::CMD_CLOSE));
              n++;
            end
            5: begin
              queue_cmd(rand_cmd(vpci_pkg::CMD_END));
              n++;
            end
            default: ;
          endcase
        end
      endcase
    end
  endtask

  task automatic wait_drained();
    // sample at the falling edge, where driver and block have settled
    while (pending_cmds.size() != 0 || in_valid || expected_words.size() != 0)
      @(negedge clk);
    // let ignored or result-free commands settle
    repeat (6) @(posedge clk);
  endtask

  task automatic write_rule(input logic v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rule_copy = v;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // segment at reset opens a subpath at the origin
    add_cmd(vpci_pkg::CMD_LINE, 0, 0, 0, 0, 0, COORD_TOP, COORD_BOTTOM, 0);
    // relative sums saturate at both ends
    add_cmd(vpci_pkg::CMD_LINE, 1, 0, 0, 0, 0, 1, -1, 0);
    add_cmd(vpci_pkg::CMD_HORIZ, 1, 0, 0, 0, 0, COORD_TOP, 5, 0);
    add_cmd(vpci_pkg::CMD_VERT, 0, 0, 0, 0, 0, 123, 0, 0);
    add_cmd(vpci_pkg::CMD_CUBIC, 0, COORD_BOTTOM, COORD_TOP, COORD_TOP, COORD_BOTTOM, 0, 0, 3);
    add_cmd(vpci_pkg::CMD_SMOOTH_CUBIC, 0, 77, 77, COORD_BOTTOM, COORD_TOP, COORD_TOP,
            COORD_TOP, 0);
    add_cmd(vpci_pkg::CMD_SMOOTH_CUBIC, 1, 0, 0, COORD_TOP, COORD_BOTTOM, COORD_BOTTOM,
            COORD_BOTTOM, 0);
    add_cmd(vpci_pkg::CMD_LINE, 1, 0, 0, 0, 0, 5, 5, 0);
    // smooth cubic after a line falls back to the pen position
    add_cmd(vpci_pkg::CMD_SMOOTH_CUBIC, 1, 0, 0, 32'sh0001_0000, -32'sh0001_0000, 9, 9, 0);
    add_cmd(vpci_pkg::CMD_QUAD, 1, COORD_TOP, COORD_BOTTOM, 0, 0, COORD_BOTTOM, COORD_TOP, 0);
    add_cmd(vpci_pkg::CMD_SMOOTH_QUAD, 0, 0, 0, 0, 0, COORD_TOP, COORD_BOTTOM, 0);
    add_cmd(vpci_pkg::CMD_CUBIC, 0, 1, 2, 3, 4, 5, 6, 0);
    add_cmd(vpci_pkg::CMD_SMOOTH_QUAD, 0, 0, 0, 0, 0, -7, -8, 0);
    add_cmd(vpci_pkg::CMD_ARC, 1, COORD_BOTTOM, COORD_TOP, COORD_TOP, 11, COORD_TOP,
            COORD_TOP, 3);
    add_cmd(vpci_pkg::CMD_ARC, 0, 32'sh0002_0000, 32'sh0003_0000, -1, -1, 0, 0, 1);
    add_cmd(vpci_pkg::CMD_CLOSE, 0, 0, 0, 0, 0, 0, 0, 0);
    add_cmd(vpci_pkg::CMD_CLOSE, 1, 0, 0, 0, 0, 0, 0, 0);
    add_cmd(vpci_pkg::CMD_MOVE, 1, 0, 0, 0, 0, COORD_BOTTOM, COORD_BOTTOM, 0);
    add_cmd(vpci_pkg::CMD_MOVE, 0, 0, 0, 0, 0, 100, 200, 0);
    add_cmd(vpci_pkg::CMD_HORIZ, 0, 0, 0, 0, 0, -300, 0, 2);
    add_cmd(vpci_pkg::CMD_MOVE, 1, 0, 0, 0, 0, COORD_TOP, COORD_TOP, 0);
    add_cmd(vpci_pkg::CMD_SMOOTH_CUBIC, 0, 0, 0, 10, 20, 30, 40, 0);
    add_cmd(vpci_pkg::CMD_END, 0, 0, 0, 0, 0, 0, 0, 0);
    add_cmd(vpci_pkg::CMD_END, 1, 0, 0, 0, 0, 0, 0, 0);
    add_cmd(4'd11, 1, -1, -1, -1, -1, -1, -1, 3);
    add_cmd(4'd15, 1, -1, -1, -1, -1, -1, -1, 3);
    add_cmd(vpci_pkg::CMD_LINE, 0, 0, 0, 0, 0, 42, 43, 0);
    wait_drained();

    write_rule(1'b1);
    queue_random_paths(300);
    wait_drained();

    write_rule(1'b0);
    queue_random_paths(300);
    wait_drained();

    write_rule(1'b1);
    queue_random_paths(300);
    wait_drained();

    write_rule(1'($urandom_range(0, 1)));
    queue_random_paths(250);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
